FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/depq_pkg.sv
// ---------------------------------------------------------------------------
// depq_pkg
// Types and constants shared by the double-ended priority queue modules.
// ---------------------------------------------------------------------------
package depq_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 72;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL_MAX = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL_MIN = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the sorted row.
    typedef struct packed {
        logic              ins;
        logic              del_min;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

FILE: design/depq_cell.sv
// ---------------------------------------------------------------------------
// depq_cell
// One entry of the ascending sorted row; shifts left or right on command.
// ---------------------------------------------------------------------------
module depq_cell
(
    input  logic                           clk,
    input  depq_pkg::cell_cmd_t            cmd,
    input  logic                           occupied,
    input  logic                           left_ge,
    input  logic [depq_pkg::DATA_W-1:0]    left_val,
    input  logic [depq_pkg::DATA_W-1:0]    right_val,
    output logic                           ge,
    output logic [depq_pkg::DATA_W-1:0]    val
);

    logic [depq_pkg::DATA_W-1:0] val_reg;
    logic [depq_pkg::DATA_W-1:0] val_next;

    // The stored entry is at or below the new value, so it stays in place.
    assign ge  = occupied && !($signed(cmd.value) < $signed(val_reg));
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins)
        begin
            if (ge)
            begin
                val_next = val_reg;
            end
            else if (left_ge)
            begin
                val_next = cmd.value;
            end
            else
            begin
                val_next = left_val;
            end
        end
        else if (cmd.del_min)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

FILE: design/double_ended_priority_queue_core.sv
// ---------------------------------------------------------------------------
// double_ended_priority_queue_core
// Min-max multiset of signed 32-bit values held in a sorted row of cells.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Ports                         | Contents
//  --------+-----------+-------------------------------+----------------------------
//  s       | in        | s_tvalid s_tready s_tdata     | tuser: op; tdata: value
//          |           | s_tuser                       |
//  m       | out       | m_tvalid m_tready m_tdata     | max, min, is_empty, status
//
// An accepted transfer updates the whole cell row at once; the block then
// waits in PH_PEND until the output stage is free, and registers the new
// maximum and minimum into it. It accepts no new item until that result has
// been registered. The maximum is a select of the top entry across all
// CAPACITY cells.
// Reset clears the fill count and the control state; cell contents are left
// as they are. A result that is not taken stalls the input after at most one
// further item.
//
// The row holds the values in ascending order in cells 0 .. count-1. An
// insert lets every cell compare the new value against its own entry: cells
// at or below the value keep it, the first larger cell takes the new value,
// and the cells above it take their left neighbor's entry. Removing the
// minimum shifts every cell from its right neighbor; removing the maximum
// only lowers the fill count.
// ---------------------------------------------------------------------------
module double_ended_priority_queue_core
#(
    parameter int CAPACITY = 64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [depq_pkg::S_DATA_W-1:0]    s_tdata,   // [31:0] value
    input  logic [depq_pkg::OP_W-1:0]        s_tuser,   // [1:0] op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [depq_pkg::M_DATA_W-1:0]    m_tdata    // [31:0] max_value,
                                                        // [63:32] min_value,
                                                        // [64] is_empty,
                                                        // [66:65] status,
                                                        // [71:67] zero
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PAD_W = depq_pkg::M_DATA_W - 2 * depq_pkg::DATA_W - 1
                           - depq_pkg::STATUS_W;

    // Two phases: idle and waiting to hand the updated row to the output.
    typedef enum logic [1:0]
    {
        PH_IDLE = 2'b01,
        PH_PEND = 2'b10
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;

    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic [depq_pkg::STATUS_W-1:0]   status_reg;
    logic [depq_pkg::STATUS_W-1:0]   status_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [depq_pkg::M_DATA_W-1:0]   out_data_reg;
    logic [depq_pkg::M_DATA_W-1:0]   out_data_next;

    logic                            s_fire;
    logic                            out_free;
    logic                            is_full;
    logic                            is_empty;
    logic [depq_pkg::OP_W-1:0]       op;
    depq_pkg::cell_cmd_t             cmd;

    logic [CAPACITY-1:0]             occ;
    logic [CAPACITY-1:0]             ge;
    logic [depq_pkg::DATA_W-1:0]     cell_val [CAPACITY];
    logic [depq_pkg::DATA_W-1:0]     max_sel;

    assign op       = s_tuser;
    assign s_tready = (phase_reg == PH_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign cmd.ins     = s_fire && (op == depq_pkg::OP_INSERT) && !is_full;
    assign cmd.del_min = s_fire && (op == depq_pkg::OP_DEL_MIN) && !is_empty;
    assign cmd.value   = s_tdata;

    // Sorted row of cells; the ends see a fixed neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                        left_ge;
        logic [depq_pkg::DATA_W-1:0] left_val;
        logic [depq_pkg::DATA_W-1:0] right_val;

        assign occ[i] = (count_reg > CW'(i));

        if (i == 0)
        begin : g_first
            assign left_ge  = 1'b1;
            assign left_val = cmd.value;
        end
        else
        begin : g_inner
            assign left_ge  = ge[i-1];
            assign left_val = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_val = cell_val[i];
        end
        else
        begin : g_body
            assign right_val = cell_val[i+1];
        end

        depq_cell u_cell
        (
            .clk       (clk),
            .cmd       (cmd),
            .occupied  (occ[i]),
            .left_ge   (left_ge),
            .left_val  (left_val),
            .right_val (right_val),
            .ge        (ge[i]),
            .val       (cell_val[i])
        );
    end

    // Fill count and status of the accepted item.
    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        if (s_fire)
        begin
            status_next = depq_pkg::ST_DONE;
            case (op)
                depq_pkg::OP_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = depq_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                depq_pkg::OP_DEL_MAX,
                depq_pkg::OP_DEL_MIN:
                begin
                    if (is_empty)
                    begin
                        status_next = depq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // The top entry is the one cell whose index is count - 1.
    always_comb
    begin
        max_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (count_reg == CW'(i + 1))
            begin
                max_sel = max_sel | cell_val[i];
            end
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (phase_reg)
            PH_IDLE:
            begin
                if (s_fire)
                begin
                    phase_next = PH_PEND;
                end
            end
            PH_PEND:
            begin
                if (out_free)
                begin
                    phase_next     = PH_IDLE;
                    out_valid_next = 1'b1;
                    if (is_empty)
                    begin
                        out_data_next = {PAD_W'(0), status_reg, 1'b1,
                                         {depq_pkg::DATA_W{1'b0}},
                                         {depq_pkg::DATA_W{1'b0}}};
                    end
                    else
                    begin
                        out_data_next = {PAD_W'(0), status_reg, 1'b0,
                                         cell_val[0], max_sel};
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: design/depq_checker.sv
// ---------------------------------------------------------------------------
// depq_checker
// Port-level checks of the double-ended priority queue result stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module depq_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [depq_pkg::S_DATA_W-1:0]    s_tdata,
    input logic [depq_pkg::OP_W-1:0]        s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [depq_pkg::M_DATA_W-1:0]    m_tdata
);

    logic [depq_pkg::STATUS_W-1:0] res_status;
    logic                          unused_in;

    assign res_status = m_tdata[66:65];
    assign unused_in  = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);

    // A stalled result keeps its contents.
    `ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // An empty queue reports zero for both ends.
    `ASSERT_IMPL(a_empty_zero, m_tvalid && m_tdata[64], m_tdata[63:0] == 64'd0)

    // A non-empty queue never reports a maximum below its minimum.
    `ASSERT_IMPL(a_order, m_tvalid && !m_tdata[64],
                 $signed(m_tdata[31:0]) >= $signed(m_tdata[63:32]))

    // Status is one of the three defined codes.
    `ASSERT_IMPL(a_status, m_tvalid,
                 res_status == depq_pkg::ST_DONE || res_status == depq_pkg::ST_EMPTY
                 || res_status == depq_pkg::ST_FULL || unused_in != unused_in)

endmodule

bind double_ended_priority_queue_core depq_checker u_depq_checker (.*);
